/* sv/assert_macros.svh */
// Assertion macros for the RTL; included by the evaluator top level.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  `ASSERT_PROP(lbl, clk, rst, !(cond))
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

/* sv/peh_pkg.sv */
// Shared types and constants for the polynomial evaluator.
// Used by peh_mac and the top level; no dependencies.
package peh_pkg;

  localparam int DATA_W        = 32;
  localparam int TC_W          = 7;
  localparam int IDX_W         = 6;
  localparam int CFG_ADDR_W    = 3;
  localparam int MAX_TERMS_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_TERM_COUNT   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BASIS        = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CLAMP_ENABLE = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CLAMP_LOW    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_CLAMP_HIGH   = 3'd4;

  localparam logic signed [DATA_W-1:0] CLAMP_HIGH_RST = 32'sd65536;

  localparam logic BASIS_MONOMIAL = 1'b0;
  localparam logic MODE_WRITE     = 1'b0;
  localparam logic MODE_EVAL      = 1'b1;

  // control for the shared multiply-add unit
  typedef struct packed {
    logic mul_en;  // capture product this cycle
    logic dbl;     // doubled product: shift by one bit less
  } mac_ctrl_t;

endpackage

/* sv/peh_store.sv */
// Coefficient store: one write port, one registered read port.
// No package dependencies.
module peh_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* sv/peh_mac.sv */
// Shared multiply-add unit: registered 32x32 product, then floor shift,
// saturate, add coefficient, subtract term, saturate. Uses peh_pkg.
module peh_mac #(
  parameter int FRAC_BITS = peh_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  peh_pkg::mac_ctrl_t                ctrl,
  input  logic signed [peh_pkg::DATA_W-1:0] op_a,
  input  logic signed [peh_pkg::DATA_W-1:0] op_b,
  input  logic signed [peh_pkg::DATA_W-1:0] coef,
  input  logic signed [peh_pkg::DATA_W-1:0] sub,
  output logic signed [peh_pkg::DATA_W-1:0] result,
  output logic                              sat
);

  localparam int DW = peh_pkg::DATA_W;
  localparam int PW = 2 * DW;
  localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] shifted;
  logic signed [DW-1:0] prod_sat;
  logic signed [DW+1:0] sum;
  logic                 prod_fits;
  logic                 sum_fits;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= op_a * op_b;
    end
  end

  always_comb begin
    // arithmetic shift of a signed value rounds toward minus infinity
    shifted   = ctrl.dbl ? (prod >>> (FRAC_BITS - 1)) : (prod >>> FRAC_BITS);
    prod_fits = (shifted[PW-1:DW-1] == '0) || (shifted[PW-1:DW-1] == '1);
    if (prod_fits) begin
      prod_sat = shifted[DW-1:0];
    end else begin
      prod_sat = shifted[PW-1] ? VMIN : VMAX;
    end
    sum      = (DW+2)'(coef) + (DW+2)'(prod_sat) - (DW+2)'(sub);
    sum_fits = (sum[DW+1:DW-1] == '0) || (sum[DW+1:DW-1] == '1);
    if (sum_fits) begin
      result = sum[DW-1:0];
    end else begin
      result = sum[DW+1] ? VMIN : VMAX;
    end
    sat = !prod_fits || !sum_fits;
  end

endmodule

/* sv/poly_eval_horner_clenshaw_unit.sv */
// Polynomial evaluator, Horner (monomial) or Clenshaw (Chebyshev), Q16.16.
// Coefficient write: no result, busy stays low; one write per cycle while busy is low.
// Evaluate with n terms (term_count capped at MAX_TERMS): the request runs S_MUL and S_ADD
// of the shared multiply-add loop for each term, then S_CLAMP, then the done register.
// busy is high until done, so no request is taken meanwhile; n = 0 gives 0 before clamp.
// Results cannot be stalled. Synchronous reset clears control and config, not the store.
`include "assert_macros.svh"
module poly_eval_horner_clenshaw_unit #(
  parameter int MAX_TERMS = peh_pkg::MAX_TERMS_DEF,
  parameter int FRAC_BITS = peh_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  mode,
  input  logic [peh_pkg::IDX_W-1:0]             coeff_index,
  input  logic signed [peh_pkg::DATA_W-1:0]     coeff_value,
  input  logic signed [peh_pkg::DATA_W-1:0]     x_value,
  output logic                                  done,
  output logic signed [peh_pkg::DATA_W-1:0]     poly_value,
  output logic                                  saturated,
  input  logic                                  cfg_we,
  input  logic [peh_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [peh_pkg::DATA_W-1:0]            cfg_wdata
);

  localparam int DW = peh_pkg::DATA_W;
  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int TW = (AW + 1 > peh_pkg::TC_W) ? AW + 1 : peh_pkg::TC_W;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_ADD, S_CLAMP} state_t;

  state_t                      state;
  logic [AW-1:0]               k;
  logic signed [DW-1:0]        acc;
  logic signed [DW-1:0]        b2;
  logic signed [DW-1:0]        x;
  logic                        sat;

  logic [peh_pkg::TC_W-1:0]    term_count;
  logic                        basis;
  logic                        clamp_enable;
  logic signed [DW-1:0]        clamp_low;
  logic signed [DW-1:0]        clamp_high;

  logic                        accept;
  logic [TW-1:0]               n_terms;
  logic [TW-1:0]               n_minus1;
  logic [TW-1:0]               idx_ext;
  logic                        wr_en;
  logic signed [DW-1:0]        coef_rd;
  logic signed [DW-1:0]        mac_result;
  logic                        mac_sat;
  logic signed [DW-1:0]        clamped;
  peh_pkg::mac_ctrl_t          mac_ctrl;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    n_terms  = (TW'(term_count) > TW'(MAX_TERMS)) ? TW'(MAX_TERMS) : TW'(term_count);
    n_minus1 = n_terms - TW'(1);
    idx_ext  = TW'(coeff_index);
    wr_en    = accept && (mode == peh_pkg::MODE_WRITE) && (idx_ext < TW'(MAX_TERMS));
  end

  peh_store #(
    .DEPTH (MAX_TERMS),
    .AW    (AW),
    .DW    (DW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_ext[AW-1:0]),
    .wr_data (coeff_value),
    .rd_addr (k),
    .rd_data (coef_rd)
  );

  // Horner: acc is r, b2 stays 0. Clenshaw: acc is b1.
  assign mac_ctrl.mul_en = (state == S_MUL);
  assign mac_ctrl.dbl    = (basis != peh_pkg::BASIS_MONOMIAL) && (k != '0);

  peh_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .op_a   (acc),
    .op_b   (x),
    .coef   (coef_rd),
    .sub    (b2),
    .result (mac_result),
    .sat    (mac_sat)
  );

  always_comb begin
    clamped = acc;
    if (clamp_enable) begin
      if (clamped > clamp_high) clamped = clamp_high;
      if (clamped < clamp_low)  clamped = clamp_low;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count   <= '0;
      basis        <= 1'b0;
      clamp_enable <= 1'b0;
      clamp_low    <= '0;
      clamp_high   <= peh_pkg::CLAMP_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        peh_pkg::REG_TERM_COUNT:   term_count   <= cfg_wdata[peh_pkg::TC_W-1:0];
        peh_pkg::REG_BASIS:        basis        <= cfg_wdata[0];
        peh_pkg::REG_CLAMP_ENABLE: clamp_enable <= cfg_wdata[0];
        peh_pkg::REG_CLAMP_LOW:    clamp_low    <= cfg_wdata;
        peh_pkg::REG_CLAMP_HIGH:   clamp_high   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && (mode == peh_pkg::MODE_EVAL)) begin
            x   <= x_value;
            acc <= '0;
            b2  <= '0;
            sat <= 1'b0;
            k   <= n_minus1[AW-1:0];
            state <= (n_terms == '0) ? S_CLAMP : S_MUL;
          end
        end
        S_MUL: begin
          state <= S_ADD;
        end
        S_ADD: begin
          acc <= mac_result;
          sat <= sat | mac_sat;
          if (basis != peh_pkg::BASIS_MONOMIAL) begin
            b2 <= acc;
          end
          if (k == '0) begin
            state <= S_CLAMP;
          end else begin
            k     <= k - AW'(1);
            state <= S_MUL;
          end
        end
        S_CLAMP: begin
          poly_value <= clamped;
          saturated  <= sat;
          done       <= 1'b1;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_PROP(a_done_after_clamp, clk, rst, done |-> $past(state == S_CLAMP))
  `ASSERT_PROP(a_eval_goes_busy, clk, rst, (accept && mode == peh_pkg::MODE_EVAL) |=> busy)
  `ASSERT_PROP(a_write_stays_idle, clk, rst, (accept && mode == peh_pkg::MODE_WRITE) |=> !busy)
  `ASSERT_PROP(a_step_count, clk, rst,
               (state == S_ADD && k != '0) |=> (state == S_MUL && k == $past(k) - AW'(1)))
  `ASSERT_NEVER(a_done_while_busy, clk, rst, done && busy)

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for poly_eval_horner_clenshaw_unit: a directed table, then random
// coefficient loads and evaluations checked against an in-bench Horner/Clenshaw predictor.
// Depends on peh_pkg and the RTL of the evaluator.
module tb_top;

  localparam logic signed [peh_pkg::DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [peh_pkg::DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam int Q_ONE = 65536;
  localparam int PHASES = 30;
  localparam int ITEMS_PER_PHASE = 40;
  localparam int DRAIN_CYCLES = 2 * peh_pkg::MAX_TERMS_DEF + 10;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DIRECTED_LEN = 31;

  typedef struct packed {
    logic signed [peh_pkg::DATA_W-1:0] value;
    logic                              sat;
  } result_t;

  typedef enum logic [1:0] {STEP_REG, STEP_WRITE, STEP_EVAL} step_kind_t;

  // reg rows: idx is the register index, value the write data
  // write rows: idx/value are the coefficient; eval rows: value is x
  typedef struct {
    step_kind_t                        kind;
    logic [peh_pkg::IDX_W-1:0]         idx;
    logic signed [peh_pkg::DATA_W-1:0] value;
    bit                                typed;
    result_t                           want;
  } step_t;

  logic                                clk;
  logic                                rst;
  logic                                start;
  logic                                busy;
  logic                                mode;
  logic [peh_pkg::IDX_W-1:0]           coeff_index;
  logic signed [peh_pkg::DATA_W-1:0]   coeff_value;
  logic signed [peh_pkg::DATA_W-1:0]   x_value;
  logic                                done;
  logic signed [peh_pkg::DATA_W-1:0]   poly_value;
  logic                                saturated;
  logic                                cfg_we;
  logic [peh_pkg::CFG_ADDR_W-1:0]      cfg_addr;
  logic [peh_pkg::DATA_W-1:0]          cfg_wdata;

  // predictor state
  logic signed [peh_pkg::DATA_W-1:0]   coeff_mirror [0:peh_pkg::MAX_TERMS_DEF-1];
  logic [peh_pkg::TC_W-1:0]            tc_cfg;
  logic                                basis_cfg;
  logic                                clamp_en_cfg;
  logic signed [peh_pkg::DATA_W-1:0]   low_cfg;
  logic signed [peh_pkg::DATA_W-1:0]   high_cfg;
  bit                                  sat_hit;

  result_t                             pending_poly [$];
  result_t                             oldest_poly;
  step_t                               directed_steps [DIRECTED_LEN];
  int                                  fail_count;
  int                                  cycle_count;

  poly_eval_horner_clenshaw_unit dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .coeff_index (coeff_index),
    .coeff_value (coeff_value),
    .x_value     (x_value),
    .done        (done),
    .poly_value  (poly_value),
    .saturated   (saturated),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // ---------------- predictor ----------------
  function automatic longint clip32(longint v);
    if (v > longint'(Q_MAX)) begin
      sat_hit = 1'b1;
      return longint'(Q_MAX);
    end
    if (v < longint'(Q_MIN)) begin
      sat_hit = 1'b1;
      return longint'(Q_MIN);
    end
    return v;
  endfunction

  // exact product, floor shift, saturate
  function automatic longint scaled_mul(longint a, longint b, int shift);
    return clip32((a * b) >>> shift);
  endfunction

  function automatic result_t predict_poly(logic signed [peh_pkg::DATA_W-1:0] x);
    int      n;
    longint  xv, r, b0, b1, b2;
    result_t res;
    sat_hit = 1'b0;
    xv = x;
    n = (tc_cfg > peh_pkg::MAX_TERMS_DEF) ? peh_pkg::MAX_TERMS_DEF : int'(tc_cfg);
    if (n == 0) begin
      r = 0;
    end else if (n == 1) begin
      r = coeff_mirror[0];
    end else if (basis_cfg == peh_pkg::BASIS_MONOMIAL) begin
      r = coeff_mirror[n-1];
      for (int i = n - 2; i >= 0; i--)
        r = clip32(scaled_mul(r, xv, peh_pkg::FRAC_BITS_DEF) + coeff_mirror[i]);
    end else begin
      b1 = 0;
      b2 = 0;
      for (int k = n - 1; k >= 1; k--) begin
        // doubled product: one fewer fraction bit dropped
        b0 = clip32(coeff_mirror[k] + scaled_mul(xv, b1, peh_pkg::FRAC_BITS_DEF - 1) - b2);
        b2 = b1;
        b1 = b0;
      end
      r = clip32(coeff_mirror[0] + scaled_mul(xv, b1, peh_pkg::FRAC_BITS_DEF) - b2);
    end
    if (clamp_en_cfg) begin
      if (r > high_cfg) r = high_cfg;
      if (r < low_cfg) r = low_cfg;
    end
    res.value = r[peh_pkg::DATA_W-1:0];
    res.sat   = sat_hit;
    return res;
  endfunction

  function automatic logic signed [peh_pkg::DATA_W-1:0] pick_q16();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 5))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return 0;
          3: return -1;
          4: return Q_ONE;
          default: return -Q_ONE;
        endcase
      end
      2, 3: return int'($urandom_range(0, 1 << 25)) - (1 << 24);
      default: return int'($urandom_range(0, 4 * Q_ONE)) - 2 * Q_ONE;
    endcase
  endfunction

  // ---------------- drivers ----------------
  // Send one request and record what it should produce. typed rows supply the result.
  task automatic request(input logic m, input logic [peh_pkg::IDX_W-1:0] idx,
                         input logic signed [peh_pkg::DATA_W-1:0] val, input int gap,
                         input bit typed, input result_t want);
    repeat (gap) begin
      @(negedge clk);
      start  <= 1'b0;
      cfg_we <= 1'b0;
    end
    @(negedge clk);
    start       <= 1'b1;
    cfg_we      <= 1'b0;
    mode        <= m;
    coeff_index <= (m == peh_pkg::MODE_WRITE) ? idx : (peh_pkg::IDX_W)'($urandom);
    coeff_value <= (m == peh_pkg::MODE_WRITE) ? val : $urandom;
    x_value     <= (m == peh_pkg::MODE_EVAL) ? val : $urandom;
    do @(posedge clk); while (busy);
    if (m == peh_pkg::MODE_WRITE)
      coeff_mirror[idx] = val;
    else
      pending_poly.push_back(typed ? want : predict_poly(val));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start  <= 1'b0;
    cfg_we <= 1'b0;
    while (pending_poly.size() != 0) @(negedge clk);
    while (busy) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_reg(input logic [peh_pkg::CFG_ADDR_W-1:0] addr,
                         input logic [peh_pkg::DATA_W-1:0] data);
    @(negedge clk);
    start     <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    case (addr)
      peh_pkg::REG_TERM_COUNT:   tc_cfg = data[peh_pkg::TC_W-1:0];
      peh_pkg::REG_BASIS:        basis_cfg = data[0];
      peh_pkg::REG_CLAMP_ENABLE: clamp_en_cfg = data[0];
      peh_pkg::REG_CLAMP_LOW:    low_cfg = data;
      peh_pkg::REG_CLAMP_HIGH:   high_cfg = data;
      default: ;
    endcase
  endtask

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_poly.size() == 0) begin
        $error("unexpected result: poly_value=%0d saturated=%0b", poly_value, saturated);
        fail_count++;
      end else begin
        oldest_poly = pending_poly.pop_front();
        if (poly_value !== oldest_poly.value) begin
          $error("poly_value mismatch: expected %0d, got %0d", oldest_poly.value, poly_value);
          fail_count++;
        end
        if (saturated !== oldest_poly.sat) begin
          $error("saturated mismatch: expected %0b, got %0b", oldest_poly.sat, saturated);
          fail_count++;
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  initial begin
    int                                gap, r, noise_sel;
    bit                                burst;
    logic [peh_pkg::TC_W-1:0]          tc;
    logic                              bas, cen;
    logic signed [peh_pkg::DATA_W-1:0] lo, hi;
    logic [peh_pkg::DATA_W-1:0]        junk;

    rst         = 1'b1;
    start       = 1'b0;
    mode        = peh_pkg::MODE_WRITE;
    coeff_index = '0;
    coeff_value = '0;
    x_value     = '0;
    cfg_we      = 1'b0;
    cfg_addr    = '0;
    cfg_wdata   = '0;
    tc_cfg       = '0;
    basis_cfg    = peh_pkg::BASIS_MONOMIAL;
    clamp_en_cfg = 1'b0;
    low_cfg      = '0;
    high_cfg     = peh_pkg::CLAMP_HIGH_RST;
    foreach (coeff_mirror[i]) coeff_mirror[i] = '0;

    directed_steps = '{
      '{STEP_EVAL,  0, 0,             1, '{0, 1'b0}},       // zero terms
      '{STEP_EVAL,  0, Q_MIN,         1, '{0, 1'b0}},
      '{STEP_REG,   peh_pkg::REG_CLAMP_LOW,    32768, 0, '{0, 1'b0}},
      '{STEP_REG,   peh_pkg::REG_CLAMP_ENABLE, 1, 0, '{0, 1'b0}},
      '{STEP_EVAL,  0, Q_MAX,         1, '{32768, 1'b0}},   // zero terms, clamped up
      '{STEP_WRITE, 0, Q_MAX,         0, '{0, 1'b0}},
      '{STEP_REG,   peh_pkg::REG_TERM_COUNT,   1, 0, '{0, 1'b0}},
      '{STEP_EVAL,  0, 5,             1, '{Q_ONE, 1'b0}},   // clamp sets no flag
      '{STEP_REG,   peh_pkg::REG_CLAMP_ENABLE, 0, 0, '{0, 1'b0}},
      '{STEP_EVAL,  0, Q_MIN,         1, '{Q_MAX, 1'b0}},   // one term
      '{STEP_WRITE, 0, Q_MIN,         0, '{0, 1'b0}},
      '{STEP_REG,   peh_pkg::REG_CLAMP_LOW,    131072, 0, '{0, 1'b0}},
      '{STEP_REG,   peh_pkg::REG_CLAMP_HIGH,   -Q_ONE, 0, '{0, 1'b0}},
      '{STEP_REG,   peh_pkg::REG_CLAMP_ENABLE, 1, 0, '{0, 1'b0}},
      '{STEP_EVAL,  0, 0,             1, '{131072, 1'b0}},  // inverted bounds give low
      '{STEP_REG,   peh_pkg::REG_CLAMP_ENABLE, 0, 0, '{0, 1'b0}},
      '{STEP_WRITE, 63, Q_ONE,        0, '{0, 1'b0}},
      '{STEP_WRITE, 1, Q_MAX,         0, '{0, 1'b0}},
      '{STEP_WRITE, 0, 0,             0, '{0, 1'b0}},
      '{STEP_REG,   peh_pkg::REG_TERM_COUNT,   2, 0, '{0, 1'b0}},
      '{STEP_EVAL,  0, Q_MAX,         1, '{Q_MAX, 1'b1}},
      '{STEP_EVAL,  0, Q_MIN,         1, '{Q_MIN, 1'b1}},
      '{STEP_EVAL,  0, Q_ONE,         1, '{Q_MAX, 1'b0}},
      '{STEP_REG,   peh_pkg::REG_BASIS,        1, 0, '{0, 1'b0}},
      '{STEP_EVAL,  0, 32768,         0, '{0, 1'b0}},
      '{STEP_EVAL,  0, Q_MIN,         0, '{0, 1'b0}},
      '{STEP_WRITE, 2, -Q_ONE,        0, '{0, 1'b0}},
      '{STEP_REG,   peh_pkg::REG_TERM_COUNT,   3, 0, '{0, 1'b0}},
      '{STEP_EVAL,  0, Q_ONE,         0, '{0, 1'b0}},
      '{STEP_REG,   peh_pkg::REG_BASIS,        0, 0, '{0, 1'b0}},
      '{STEP_EVAL,  0, -Q_ONE,        0, '{0, 1'b0}}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_steps[s]) begin
      gap = $urandom_range(0, 10);
      case (directed_steps[s].kind)
        STEP_REG: begin
          wait_idle();
          set_reg(directed_steps[s].idx[peh_pkg::CFG_ADDR_W-1:0], directed_steps[s].value);
        end
        STEP_WRITE: request(peh_pkg::MODE_WRITE, directed_steps[s].idx,
                            directed_steps[s].value, gap, 1'b0, '0);
        default: request(peh_pkg::MODE_EVAL, '0, directed_steps[s].value, gap,
                         directed_steps[s].typed, directed_steps[s].want);
      endcase
    end

    // load the whole store; only entries below 3 are in use meanwhile
    wait_idle();
    set_reg(peh_pkg::REG_TERM_COUNT, $urandom_range(0, 3));
    for (int i = 0; i < peh_pkg::MAX_TERMS_DEF; i++) begin
      request(peh_pkg::MODE_WRITE, (peh_pkg::IDX_W)'(i), pick_q16(), $urandom_range(0, 10),
              1'b0, '0);
      if (i % 4 == 3)
        request(peh_pkg::MODE_EVAL, '0, pick_q16(), $urandom_range(0, 10), 1'b0, '0);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      r = $urandom_range(0, 19);
      case (p)
        0: tc = 7'd127;
        1: tc = 7'd64;
        2: tc = 7'd0;
        3: tc = 7'd1;
        default: begin
          if (r == 0)      tc = $urandom_range(0, 1);
          else if (r == 1) tc = $urandom_range(9, 40);
          else if (r == 2) tc = $urandom_range(64, 127);
          else             tc = $urandom_range(2, 8);
        end
      endcase
      bas = (p < 4) ? p[1] : 1'($urandom_range(0, 1));
      cen = (p < 4) ? p[0] : ($urandom_range(0, 2) == 0);
      noise_sel = (p == 0) ? 1 : $urandom_range(0, 3);
      case (noise_sel)
        0: begin
          lo = -int'($urandom_range(0, 4 * Q_ONE));
          hi = int'($urandom_range(0, 4 * Q_ONE));
        end
        1: begin
          lo = Q_MIN;
          hi = Q_MAX;
        end
        2: begin
          lo = pick_q16();
          hi = pick_q16();
        end
        default: begin
          lo = pick_q16();
          hi = lo - int'($urandom_range(1, Q_ONE));
        end
      endcase
      // unused upper bits of the narrow registers must be ignored
      junk = ($urandom_range(0, 3) == 0) ? $urandom : '0;
      set_reg(peh_pkg::REG_TERM_COUNT, (junk & ~32'h7F) | tc);
      set_reg(peh_pkg::REG_BASIS, (junk & ~32'h1) | bas);
      set_reg(peh_pkg::REG_CLAMP_ENABLE, (junk & ~32'h1) | cen);
      set_reg(peh_pkg::REG_CLAMP_LOW, lo);
      set_reg(peh_pkg::REG_CLAMP_HIGH, hi);

      burst = $urandom_range(0, 1);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(0, 39) == 0)
          wait_idle();
        gap = burst ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 99) < 55)
          request(peh_pkg::MODE_EVAL, '0, pick_q16(), gap, 1'b0, '0);
        else
          request(peh_pkg::MODE_WRITE,
                  (peh_pkg::IDX_W)'($urandom_range(0, peh_pkg::MAX_TERMS_DEF - 1)),
                  pick_q16(), gap, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_poly.size() != 0) begin
      $error("%0d results never arrived", pending_poly.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/peh_pkg.sv
sv/peh_store.sv
sv/peh_mac.sv
sv/poly_eval_horner_clenshaw_unit.sv
bench/tb_top.sv
